// ===== rtl/stream_admission_controller_defines.svh =====
// Assertion macros shared by the stream admission controller RTL.
`ifndef STREAM_ADMISSION_CONTROLLER_DEFINES_SVH
`define STREAM_ADMISSION_CONTROLLER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define SAC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("sac assertion failed");

// Next-cycle implication, disabled during reset.
`define SAC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("sac assertion failed");

`endif

// ===== rtl/sac_pkg.sv =====
// Package of types and constants for the stream admission controller.
package sac_pkg;

	localparam int STREAM_SLOTS_DEF = 256;
	localparam int STAT_BITS_DEF    = 32;
	localparam int LEVEL_W          = 16;
	localparam int OUT_STAT_W       = 32;
	localparam int ID_W             = 8;
	localparam int ID_VALUES        = 1 << ID_W;
	localparam int OUT_DATA_W       = 232;
	localparam int OUT_PAD_W        = 5;

	typedef enum logic [1:0] {
		OP_ADMIT   = 2'd0,
		OP_PROMOTE = 2'd1,
		OP_CLOSE   = 2'd2,
		OP_NONE    = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		SLOT_NONE    = 2'd0,
		SLOT_ACTIVE  = 2'd1,
		SLOT_BACKLOG = 2'd2
	} slot_t;

	typedef enum logic [1:0] {
		DEC_ADMITTED     = 2'd0,
		DEC_QUEUED       = 2'd1,
		DEC_SHED_ACTIVE  = 2'd2,
		DEC_SHED_BACKLOG = 2'd3
	} dec_t;

	typedef enum logic {
		REG_ACTIVE_CAP  = 1'b0,
		REG_BACKLOG_CAP = 1'b1
	} reg_idx_t;

	typedef struct packed {
		logic  en;
		slot_t data;
	} slot_wr_t;

	typedef struct packed {
		logic [OUT_STAT_W-1:0] shed_total;
		logic [OUT_STAT_W-1:0] backlog_cap_hit_total;
		logic [OUT_STAT_W-1:0] active_cap_hit_total;
		logic [OUT_STAT_W-1:0] admitted_total;
		logic [OUT_STAT_W-1:0] offered_total;
		logic [LEVEL_W-1:0]    backlog_high_mark;
		logic [LEVEL_W-1:0]    active_high_mark;
		logic [LEVEL_W-1:0]    backlog_now;
		logic [LEVEL_W-1:0]    active_now;
		logic                  promoted;
		dec_t                  decision;
	} result_t;

endpackage

// ===== rtl/sac_cfg_regs.sv =====
// APB configuration registers: active cap and backlog cap.
module sac_cfg_regs
	import sac_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [2:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	output logic [LEVEL_W-1:0] act_limit,
	output logic [LEVEL_W-1:0] bl_limit
);

	logic [LEVEL_W-1:0] act_limit_q;
	logic [LEVEL_W-1:0] bl_limit_q;
	logic               wr;
	reg_idx_t           sel;

	assign pready = 1'b1;
	assign wr     = psel && penable && pwrite && pready;
	assign sel    = reg_idx_t'(paddr[2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_limit_q <= '0;
			bl_limit_q  <= '0;
		end else if (wr) begin
			unique case (sel)
				REG_ACTIVE_CAP:  act_limit_q <= pwdata[LEVEL_W-1:0];
				REG_BACKLOG_CAP: bl_limit_q  <= pwdata[LEVEL_W-1:0];
				default:         act_limit_q <= act_limit_q;
			endcase
		end
	end

	always_comb begin
		unique case (sel)
			REG_ACTIVE_CAP:  prdata = 32'(act_limit_q);
			REG_BACKLOG_CAP: prdata = 32'(bl_limit_q);
			default:         prdata = '0;
		endcase
	end

	assign act_limit = act_limit_q;
	assign bl_limit  = bl_limit_q;

endmodule

// ===== rtl/sac_slot_mem.sv =====
// Slot table memory: one write port, registered read, clearing pass after reset.
module sac_slot_mem
	import sac_pkg::*;
#(
	parameter int DEPTH = STREAM_SLOTS_DEF,
	parameter int IDX_W = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             rd_en,
	input  logic [IDX_W-1:0] rd_addr,
	output logic [1:0]       rd_data,
	input  logic             wr_en,
	input  logic [IDX_W-1:0] wr_addr,
	input  logic [1:0]       wr_data,
	output logic             clearing
);

	logic [1:0]       mem [DEPTH];
	logic [IDX_W-1:0] clr_cnt_q;
	logic             clearing_q;
	logic             we;
	logic [IDX_W-1:0] waddr;
	logic [1:0]       wdata;
	logic [1:0]       rd_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q  <= '0;
			clearing_q <= 1'b1;
		end else if (clearing_q) begin
			if (clr_cnt_q == IDX_W'(DEPTH - 1)) begin
				clearing_q <= 1'b0;
			end else begin
				clr_cnt_q <= clr_cnt_q + 1'b1;
			end
		end
	end

	assign we    = clearing_q || wr_en;
	assign waddr = clearing_q ? clr_cnt_q : wr_addr;
	assign wdata = clearing_q ? 2'(SLOT_NONE) : wr_data;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data  = rd_data_q;
	assign clearing = clearing_q;

endmodule

// ===== rtl/sac_update.sv =====
// Level, peak and statistics state with the per-item update logic.
module sac_update
	import sac_pkg::*;
#(
	parameter int STAT_BITS = STAT_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               fire,
	input  op_t                op,
	input  logic               named,
	input  slot_t              cur_slot,
	input  logic [LEVEL_W-1:0] act_limit,
	input  logic [LEVEL_W-1:0] bl_limit,
	output slot_wr_t           slot_wr,
	output result_t            result
);

	logic [LEVEL_W-1:0]   act_q, bl_q, apk_q, bpk_q;
	logic [LEVEL_W-1:0]   act_n, bl_n, apk_n, bpk_n;
	logic [STAT_BITS-1:0] off_q, adm_q, ahit_q, bhit_q, shed_q;
	logic [STAT_BITS-1:0] off_n, adm_n, ahit_n, bhit_n, shed_n;
	logic                 a_room, b_room;
	dec_t                 dec;
	logic                 prom;

	function automatic logic [STAT_BITS-1:0] sat_inc(input logic [STAT_BITS-1:0] c);
		return (&c) ? c : c + STAT_BITS'(1);
	endfunction

	function automatic logic [LEVEL_W-1:0] lvl_dec(input logic [LEVEL_W-1:0] v);
		return (v != '0) ? v - LEVEL_W'(1) : v;
	endfunction

	assign a_room = act_q < act_limit;
	assign b_room = bl_q < bl_limit;

	always_comb begin
		act_n   = act_q;
		bl_n    = bl_q;
		apk_n   = apk_q;
		bpk_n   = bpk_q;
		off_n   = off_q;
		adm_n   = adm_q;
		ahit_n  = ahit_q;
		bhit_n  = bhit_q;
		shed_n  = shed_q;
		dec     = DEC_ADMITTED;
		prom    = 1'b0;
		slot_wr = '{en: 1'b0, data: SLOT_NONE};
		unique case (op)
			OP_ADMIT: begin
				off_n = sat_inc(off_q);
				priority if (a_room) begin
					act_n = act_q + LEVEL_W'(1);
					adm_n = sat_inc(adm_q);
					if (act_q >= apk_q) apk_n = act_n;
					slot_wr = '{en: named, data: SLOT_ACTIVE};
					dec = DEC_ADMITTED;
				end else if (b_room) begin
					bl_n  = bl_q + LEVEL_W'(1);
					adm_n = sat_inc(adm_q);
					if (bl_q >= bpk_q) bpk_n = bl_n;
					slot_wr = '{en: named, data: SLOT_BACKLOG};
					dec = DEC_QUEUED;
				end else if (bl_limit == '0) begin
					ahit_n = sat_inc(ahit_q);
					shed_n = sat_inc(shed_q);
					dec = DEC_SHED_ACTIVE;
				end else begin
					bhit_n = sat_inc(bhit_q);
					shed_n = sat_inc(shed_q);
					dec = DEC_SHED_BACKLOG;
				end
			end
			OP_PROMOTE: begin
				if (named && cur_slot == SLOT_BACKLOG && a_room) begin
					act_n = act_q + LEVEL_W'(1);
					bl_n  = lvl_dec(bl_q);
					if (act_q >= apk_q) apk_n = act_n;
					slot_wr = '{en: 1'b1, data: SLOT_ACTIVE};
					prom = 1'b1;
				end
			end
			OP_CLOSE: begin
				priority if (named) begin
					if (cur_slot != SLOT_NONE) begin
						slot_wr = '{en: 1'b1, data: SLOT_NONE};
						if (cur_slot == SLOT_ACTIVE) act_n = lvl_dec(act_q);
						else bl_n = lvl_dec(bl_q);
					end
				end else if (act_q != '0) begin
					act_n = lvl_dec(act_q);
				end else begin
					bl_n = lvl_dec(bl_q);
				end
			end
			OP_NONE: begin
				prom = 1'b0;
			end
			default: begin
				prom = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q  <= '0;
			bl_q   <= '0;
			apk_q  <= '0;
			bpk_q  <= '0;
			off_q  <= '0;
			adm_q  <= '0;
			ahit_q <= '0;
			bhit_q <= '0;
			shed_q <= '0;
		end else if (fire) begin
			act_q  <= act_n;
			bl_q   <= bl_n;
			apk_q  <= apk_n;
			bpk_q  <= bpk_n;
			off_q  <= off_n;
			adm_q  <= adm_n;
			ahit_q <= ahit_n;
			bhit_q <= bhit_n;
			shed_q <= shed_n;
		end
	end

	always_comb begin
		result.decision              = dec;
		result.promoted              = prom;
		result.active_now            = act_n;
		result.backlog_now           = bl_n;
		result.active_high_mark      = apk_n;
		result.backlog_high_mark     = bpk_n;
		result.offered_total         = OUT_STAT_W'(off_n);
		result.admitted_total        = OUT_STAT_W'(adm_n);
		result.active_cap_hit_total  = OUT_STAT_W'(ahit_n);
		result.backlog_cap_hit_total = OUT_STAT_W'(bhit_n);
		result.shed_total            = OUT_STAT_W'(shed_n);
	end

endmodule

// ===== rtl/stream_admission_controller.sv =====
// Stream admission controller top level: stream ports, pipeline control, slot forwarding.
//
// One request is taken per clock cycle when the result side keeps up; a request
// is held in stage 1 and its result is registered on the output side. The slot
// table is read when a request is taken and written back when that request leaves
// stage 1, with the written entry forwarded to a following request for the same
// slot. After reset the slot table is swept clear, one entry a cycle, during which
// s_tready stays low; configuration writes are taken throughout. Stream ids are
// taken modulo STREAM_SLOTS. Statistics counters saturate at 2^STAT_BITS - 1.
`include "stream_admission_controller_defines.svh"

module stream_admission_controller
	import sac_pkg::*;
#(
	parameter int STREAM_SLOTS = STREAM_SLOTS_DEF,
	parameter int STAT_BITS    = STAT_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [ID_W-1:0]       s_tdata,   // stream number
	input  logic [2:0]            s_tuser,   // operation[1:0], has_id[2]
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// decision[1:0], promoted[2], active_now[18:3], backlog_now[34:19],
	// active_high_mark[50:35], backlog_high_mark[66:51], offered_total[98:67],
	// admitted_total[130:99], active_cap_hit_total[162:131],
	// backlog_cap_hit_total[194:163], shed_total[226:195], zero pad[231:227]
	output logic [OUT_DATA_W-1:0] m_tdata,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [2:0]            paddr,
	input  logic [31:0]           pwdata,
	output logic [31:0]           prdata,
	output logic                  pready
);

	localparam int IDX_W = $clog2(STREAM_SLOTS);

	logic [IDX_W-1:0]   slot_lut [ID_VALUES];
	logic [IDX_W-1:0]   in_idx;
	logic               accept;
	logic               fire_s1;
	logic               valid_s1;
	op_t                op_s1;
	logic               named_s1;
	logic [IDX_W-1:0]   idx_s1;
	logic               fwd_q;
	slot_t              fwd_data_q;
	logic [1:0]         rd_data;
	slot_t              cur_slot;
	logic               clearing;
	logic               out_valid_q;
	result_t            res_q;
	result_t            result;
	slot_wr_t           slot_wr;
	logic [LEVEL_W-1:0] act_limit;
	logic [LEVEL_W-1:0] bl_limit;

	for (genvar g = 0; g < ID_VALUES; g++) begin : g_lut
		assign slot_lut[g] = IDX_W'(g % STREAM_SLOTS);
	end

	assign in_idx   = slot_lut[s_tdata];
	assign fire_s1  = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !clearing && (!valid_s1 || fire_s1);
	assign accept   = s_tvalid && s_tready;
	assign cur_slot = fwd_q ? fwd_data_q : slot_t'(rd_data);

	sac_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.act_limit (act_limit),
		.bl_limit  (bl_limit)
	);

	sac_slot_mem #(
		.DEPTH (STREAM_SLOTS),
		.IDX_W (IDX_W)
	) u_mem (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_en    (accept),
		.rd_addr  (in_idx),
		.rd_data  (rd_data),
		.wr_en    (fire_s1 && slot_wr.en),
		.wr_addr  (idx_s1),
		.wr_data  (2'(slot_wr.data)),
		.clearing (clearing)
	);

	sac_update #(
		.STAT_BITS (STAT_BITS)
	) u_upd (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (fire_s1),
		.op        (op_s1),
		.named     (named_s1),
		.cur_slot  (cur_slot),
		.act_limit (act_limit),
		.bl_limit  (bl_limit),
		.slot_wr   (slot_wr),
		.result    (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			fwd_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
				fwd_q    <= fire_s1 && slot_wr.en && (idx_s1 == in_idx);
			end else if (fire_s1) begin
				valid_s1 <= 1'b0;
				fwd_q    <= 1'b0;
			end
			if (fire_s1) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1      <= op_t'(s_tuser[1:0]);
			named_s1   <= s_tuser[2];
			idx_s1     <= in_idx;
			fwd_data_q <= slot_wr.data;
		end
		if (fire_s1) begin
			res_q <= result;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {
		OUT_PAD_W'(0),
		res_q.shed_total,
		res_q.backlog_cap_hit_total,
		res_q.active_cap_hit_total,
		res_q.admitted_total,
		res_q.offered_total,
		res_q.backlog_high_mark,
		res_q.active_high_mark,
		res_q.backlog_now,
		res_q.active_now,
		res_q.promoted,
		2'(res_q.decision)
	};

	`SAC_ASSERT_NOW(a_no_accept_clearing, clk, arst_n, clearing, !s_tready)
	`SAC_ASSERT_NOW(a_fwd_needs_item, clk, arst_n, fwd_q, valid_s1)
	`SAC_ASSERT_NOW(a_stall_blocks_input, clk, arst_n, valid_s1 && !fire_s1, !s_tready)
	`SAC_ASSERT_NEXT(a_fire_gives_result, clk, arst_n, fire_s1, m_tvalid)

endmodule
